FILE: hdl/spq_pkg.sv
// Shared types, constants and codes for the sorted priority queue unit.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W   = 14;
    localparam int RANK_W = 3;
    localparam int YEAR_W = 14;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   record_id;
        logic [RANK_W-1:0] rank;
        logic [YEAR_W-1:0] rank_year;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [RANK_W-1:0] out_rank;
        logic [YEAR_W-1:0] out_year;
        logic              last;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // take the input item and register the cell compares
        logic commit;    // apply the command and load its first result
        logic emit;      // load the next listed record
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_list;   // held command is a list
        logic empty;     // store holds no record
        logic list_end;  // list index sits on the last record
        logic out_free;  // output register can take a result this cycle
    } dp_stat_t;

endpackage

FILE: hdl/spq_ctrl.sv
// Command sequencer for the sorted priority queue unit.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_LIST  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decode next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        cmd.emit    = 1'b0;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    if (stat.is_list && !stat.empty && !stat.list_end) begin
                        state_next = S_LIST;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.list_end) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/spq_dp.sv
// Record cells, compare flags, fill count and output register of the queue.
module spq_dp
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  logic      m_ready,
    output logic      m_valid,
    output out_item_t m_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat
);

    logic [ID_W-1:0]   slot_id_reg   [DEPTH];
    logic [RANK_W-1:0] slot_rank_reg [DEPTH];
    logic [YEAR_W-1:0] slot_year_reg [DEPTH];
    logic [ID_W-1:0]   slot_id_next   [DEPTH];
    logic [RANK_W-1:0] slot_rank_next [DEPTH];
    logic [YEAR_W-1:0] slot_year_next [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    in_item_t         item_reg;
    logic [DEPTH-1:0] gt_reg;
    logic [DEPTH-1:0] gt_next;
    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] match_next;
    logic [DEPTH-1:0] after;
    logic [DEPTH-1:0] first;

    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_data_reg;
    out_item_t         m_data_next;

    logic              full;
    logic              empty;
    logic              found;
    logic              list_end;
    logic              out_free;
    logic [CNT_W-1:0]  tail_cnt;
    logic [IDX_W-1:0]  rd_idx;
    logic [ID_W-1:0]   del_id;
    logic [RANK_W-1:0] del_rank;
    logic [YEAR_W-1:0] del_year;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign found    = |match_reg;
    assign tail_cnt = count_reg - CNT_W'(1);
    assign list_end = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign rd_idx   = (item_reg.cmd == CMD_LIST) ? idx_reg : tail_cnt[IDX_W-1:0];

    assign stat.is_list  = (item_reg.cmd == CMD_LIST);
    assign stat.empty    = empty;
    assign stat.list_end = list_end;
    assign stat.out_free = out_free;

    // Per-cell compares against the incoming item: key order and id match
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) >= count_reg) begin
                gt_next[i] = 1'b1;
            end else if (slot_rank_reg[i] != s_data.rank) begin
                gt_next[i] = slot_rank_reg[i] > s_data.rank;
            end else begin
                gt_next[i] = slot_year_reg[i] > s_data.rank_year;
            end
            match_next[i] = (CNT_W'(i) < count_reg) &&
                            (slot_id_reg[i] == s_data.record_id);
        end
    end

    // Mark cells at and after the first id match
    always_comb begin
        logic [DEPTH-1:0] ones;
        ones = '1;
        for (int i = 0; i < DEPTH; i++) begin
            after[i] = |(match_reg & ~(ones << (i + 1)));
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                first[i] = match_reg[i];
            end else begin
                first[i] = match_reg[i] && !after[i-1];
            end
        end
    end

    // Pick the record that a delete removes
    always_comb begin
        del_id   = '0;
        del_rank = '0;
        del_year = '0;
        for (int i = 0; i < DEPTH; i++) begin
            del_id   = del_id   | (slot_id_reg[i]   & {ID_W{first[i]}});
            del_rank = del_rank | (slot_rank_reg[i] & {RANK_W{first[i]}});
            del_year = del_year | (slot_year_reg[i] & {YEAR_W{first[i]}});
        end
    end

    // Apply the command: shift cells, update count, build the result
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_id_next[i]   = slot_id_reg[i];
            slot_rank_next[i] = slot_rank_reg[i];
            slot_year_next[i] = slot_year_reg[i];
        end
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.capture) begin
            idx_next = '0;
        end

        if (cmd.commit) begin
            m_valid_next     = 1'b1;
            m_data_next      = '0;
            m_data_next.last = 1'b1;
            case (item_reg.cmd)
                CMD_INSERT: begin
                    if (full) begin
                        m_data_next.status = ST_FULL;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (gt_reg[i] && (i == 0 || !gt_reg[(i > 0) ? i - 1 : 0])) begin
                                slot_id_next[i]   = item_reg.record_id;
                                slot_rank_next[i] = item_reg.rank;
                                slot_year_next[i] = item_reg.rank_year;
                            end else if (i > 0 && gt_reg[(i > 0) ? i - 1 : 0]) begin
                                slot_id_next[i]   = slot_id_reg[(i > 0) ? i - 1 : 0];
                                slot_rank_next[i] = slot_rank_reg[(i > 0) ? i - 1 : 0];
                                slot_year_next[i] = slot_year_reg[(i > 0) ? i - 1 : 0];
                            end
                        end
                        count_next           = count_reg + CNT_W'(1);
                        m_data_next.status   = ST_OK;
                        m_data_next.out_id   = item_reg.record_id;
                        m_data_next.out_rank = item_reg.rank;
                        m_data_next.out_year = item_reg.rank_year;
                    end
                end
                CMD_DELETE: begin
                    if (!found) begin
                        m_data_next.status = ST_NOTFOUND;
                    end else begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            if (after[i]) begin
                                slot_id_next[i]   = slot_id_reg[i+1];
                                slot_rank_next[i] = slot_rank_reg[i+1];
                                slot_year_next[i] = slot_year_reg[i+1];
                            end
                        end
                        count_next           = tail_cnt;
                        m_data_next.status   = ST_OK;
                        m_data_next.out_id   = del_id;
                        m_data_next.out_rank = del_rank;
                        m_data_next.out_year = del_year;
                    end
                end
                CMD_POP: begin
                    if (empty) begin
                        m_data_next.status = ST_EMPTY;
                    end else begin
                        count_next           = tail_cnt;
                        m_data_next.status   = ST_OK;
                        m_data_next.out_id   = slot_id_reg[rd_idx];
                        m_data_next.out_rank = slot_rank_reg[rd_idx];
                        m_data_next.out_year = slot_year_reg[rd_idx];
                    end
                end
                CMD_LIST: begin
                    if (empty) begin
                        m_data_next.status = ST_EMPTY;
                    end else begin
                        m_data_next.status   = ST_OK;
                        m_data_next.out_id   = slot_id_reg[rd_idx];
                        m_data_next.out_rank = slot_rank_reg[rd_idx];
                        m_data_next.out_year = slot_year_reg[rd_idx];
                        m_data_next.last     = list_end;
                        idx_next             = idx_reg + IDX_W'(1);
                    end
                end
                default: begin
                    m_data_next.status = ST_OK;
                end
            endcase
        end

        // Stream the remaining records of a list
        if (cmd.emit) begin
            m_valid_next         = 1'b1;
            m_data_next.status   = ST_OK;
            m_data_next.out_id   = slot_id_reg[rd_idx];
            m_data_next.out_rank = slot_rank_reg[rd_idx];
            m_data_next.out_year = slot_year_reg[rd_idx];
            m_data_next.last     = list_end;
            idx_next             = idx_reg + IDX_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
        if (cmd.capture) begin
            item_reg  <= s_data;
            gt_reg    <= gt_next;
            match_reg <= match_next;
        end
        for (int i = 0; i < DEPTH; i++) begin
            slot_id_reg[i]   <= slot_id_next[i];
            slot_rank_reg[i] <= slot_rank_next[i];
            slot_year_reg[i] <= slot_year_next[i];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue unit: sequencer plus record datapath.
//
//  Channel | Ports                     | Direction | Carries
//  --------+---------------------------+-----------+---------------------------------
//  s_      | s_valid, s_ready, s_data  | in        | command item (cmd, id, rank, year)
//  m_      | m_valid, m_ready, m_data  | out       | result item (status, record, last)
//
//  An accepted item registers the per-cell key and id compares; once the output register
//  is free, the record cells shift and the result register loads.
//  A list streams its records from the output register, one record a cycle while the m_ channel does not stall.
//  Reset (aresetn low, synchronous) empties the store and drops any pending result.
//  A stalled m_ channel holds the sequencer; s_ready is high only between commands.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    spq_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (dp_cmd),
        .stat    (dp_stat)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the sorted priority queue unit.
`timescale 1ns / 1ps

import spq_pkg::*;

// Tracks the records the unit should hold and the results it owes.
class queue_tracker;
    logic [ID_W-1:0]   held_id[DEPTH];
    logic [RANK_W-1:0] held_rank[DEPTH];
    logic [YEAR_W-1:0] held_year[DEPTH];
    int                held;
    out_item_t         owed_results[$];
    int                errors;
    int                seen;

    function new();
        held = 0;
        errors = 0;
        seen = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    function void owe(logic [1:0] st, logic [ID_W-1:0] id, logic [RANK_W-1:0] rk,
                      logic [YEAR_W-1:0] yr, logic lst);
        out_item_t r;
        r.status = st;
        r.out_id = id;
        r.out_rank = rk;
        r.out_year = yr;
        r.last = lst;
        owed_results.push_back(r);
    endfunction

    // true when held slot i sorts strictly after the given key
    function bit sorts_after(int i, logic [RANK_W-1:0] rk, logic [YEAR_W-1:0] yr);
        if (held_rank[i] != rk)
            return held_rank[i] > rk;
        return held_year[i] > yr;
    endfunction

    // An identifier that is currently stored, or a random one when empty
    function logic [ID_W-1:0] some_held_id();
        if (held == 0)
            return ID_W'($urandom_range(0, 9999));
        return held_id[$urandom_range(0, held - 1)];
    endfunction

    // Apply one accepted command to the record store and queue its results
    function void note_command(in_item_t c);
        int pos;
        int k;
        pos = held;
        case (c.cmd)
            CMD_INSERT: begin
                if (held >= DEPTH) begin
                    owe(ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    for (k = 0; k < held; k++) begin
                        if (sorts_after(k, c.rank, c.rank_year)) begin
                            pos = k;
                            break;
                        end
                    end
                    for (k = held; k > pos; k--) begin
                        held_id[k] = held_id[k-1];
                        held_rank[k] = held_rank[k-1];
                        held_year[k] = held_year[k-1];
                    end
                    held_id[pos] = c.record_id;
                    held_rank[pos] = c.rank;
                    held_year[pos] = c.rank_year;
                    held++;
                    owe(ST_OK, c.record_id, c.rank, c.rank_year, 1'b1);
                end
            end
            CMD_DELETE: begin
                for (k = 0; k < held; k++) begin
                    if (held_id[k] == c.record_id) begin
                        pos = k;
                        break;
                    end
                end
                if (pos >= held) begin
                    owe(ST_NOTFOUND, '0, '0, '0, 1'b1);
                end else begin
                    owe(ST_OK, held_id[pos], held_rank[pos], held_year[pos], 1'b1);
                    for (k = pos; k + 1 < held; k++) begin
                        held_id[k] = held_id[k+1];
                        held_rank[k] = held_rank[k+1];
                        held_year[k] = held_year[k+1];
                    end
                    held--;
                end
            end
            default: begin
                if (held == 0) begin
                    owe(ST_EMPTY, '0, '0, '0, 1'b1);
                end else if (c.cmd == CMD_POP) begin
                    owe(ST_OK, held_id[held-1], held_rank[held-1], held_year[held-1],
                        1'b1);
                    held--;
                end else begin
                    for (k = 0; k < held; k++)
                        owe(ST_OK, held_id[k], held_rank[k], held_year[k],
                            logic'(k + 1 == held));
                end
            end
        endcase
    endfunction

    task report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= 60)
            $display("%0t result %0d: %s got %0d want %0d", $realtime, seen, what,
                     got, want);
    endtask

    // Compare one accepted result with the oldest owed one
    task check_result(out_item_t got);
        out_item_t want;
        seen++;
        if (owed_results.size() == 0) begin
            report_mismatch("result with nothing owed, status", got.status, -1);
        end else begin
            want = owed_results.pop_front();
            if (got.status != want.status)
                report_mismatch("status", got.status, want.status);
            if (got.out_id != want.out_id)
                report_mismatch("out_id", got.out_id, want.out_id);
            if (got.out_rank != want.out_rank)
                report_mismatch("out_rank", got.out_rank, want.out_rank);
            if (got.out_year != want.out_year)
                report_mismatch("out_year", got.out_year, want.out_year);
            if (got.last != want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask
endclass

module testbench;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 320;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    queue_tracker tracker;
    int           cycles;
    int           rx_wait;
    bit           tx_gappy;
    bit           rx_gappy;

    sorted_priority_queue_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hold off the run at a generous cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("sorted_priority_queue_unit: mismatch");
        $finish;
    end

    // Stall the result channel between items, in calm and gappy stretches
    initial begin
        m_ready = 1'b0;
        rx_wait = 0;
        rx_gappy = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every accepted result item
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_result(m_data);
                if ($urandom_range(0, 24) == 0)
                    rx_gappy = ~rx_gappy;
                rx_wait = rx_gappy ? $urandom_range(0, 18) : 0;
            end
        end
    end

    // Present one command item and hold it until accepted
    task send_cmd(logic [1:0] cmd, int id, int rk, int yr);
        in_item_t item;
        int gap;
        item.cmd = cmd;
        item.record_id = ID_W'(id);
        item.rank = RANK_W'(rk);
        item.rank_year = YEAR_W'(yr);
        if ($urandom_range(0, 19) == 0)
            tx_gappy = ~tx_gappy;
        gap = tx_gappy ? $urandom_range(0, 18) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        tracker.note_command(item);
    endtask

    function int pick_year();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 9999;
            2: return $urandom_range(0, 3);
            default: return $urandom_range(0, 9999);
        endcase
    endfunction

    function int pick_id();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(0, 9999);
    endfunction

    // Random command biased towards filling or draining the store
    task send_random(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 60 : 25))
            send_cmd(CMD_INSERT, pick_id(), $urandom_range(0, 7), pick_year());
        else if (roll < (filling ? 75 : 60))
            send_cmd(CMD_DELETE, tracker.some_held_id(), $urandom_range(0, 7),
                     $urandom_range(0, 9999));
        else if (roll < (filling ? 85 : 85))
            send_cmd(CMD_POP, $urandom_range(0, 9999), $urandom_range(0, 7),
                     $urandom_range(0, 9999));
        else if (roll < 95)
            send_cmd(CMD_LIST, $urandom_range(0, 9999), $urandom_range(0, 7),
                     $urandom_range(0, 9999));
        else
            send_cmd(CMD_DELETE, $urandom_range(0, 9999), $urandom_range(0, 7),
                     $urandom_range(0, 9999));
    endtask

    initial begin
        int k;
        tracker = new();
        tx_gappy = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty store: list, pop and delete all miss
        send_cmd(CMD_LIST, 9999, 7, 9999);
        send_cmd(CMD_POP, 0, 0, 0);
        send_cmd(CMD_DELETE, 5, 7, 9999);

        // Key extremes, equal keys after existing ones, duplicate identifiers
        send_cmd(CMD_INSERT, 9999, 7, 9999);
        send_cmd(CMD_INSERT, 0, 0, 0);
        send_cmd(CMD_INSERT, 100, 3, 500);
        send_cmd(CMD_INSERT, 101, 3, 500);
        send_cmd(CMD_INSERT, 102, 3, 499);
        send_cmd(CMD_INSERT, 100, 0, 9999);
        for (k = 0; k < 10; k++)
            send_cmd(CMD_INSERT, 4096 + k, 5, 1234);

        // Full store: refused insert, full list, then a delete by id and pops from the tail
        send_cmd(CMD_INSERT, 8191, 1, 1);
        send_cmd(CMD_LIST, 0, 0, 0);
        send_cmd(CMD_DELETE, 100, 0, 0);
        send_cmd(CMD_POP, 16383 % 10000, 7, 9999);
        send_cmd(CMD_POP, 0, 0, 0);
        send_cmd(CMD_LIST, 1, 1, 1);

        // Alternate filling and draining stretches
        for (k = 0; k < RANDOM_ITEMS; k++)
            send_random(((k / 40) % 2) == 0);

        @(negedge aclk);
        s_valid <= 1'b0;

        while (tracker.pending() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (tracker.errors == 0)
            $display("sorted_priority_queue_unit: match");
        else
            $display("sorted_priority_queue_unit: mismatch");
        $finish;
    end
endmodule
